### rtl/core/llm_pkg.sv
`default_nettype none
package llm_pkg;

   // Field and state widths.
   localparam int CountWidth   = 32;
   localparam int AvgFracBits  = 16;
   localparam int AvgWidth     = 48;
   localparam int TicksWidth   = 32;
   localparam int RunWidth     = 16;
   localparam int PeriodWidth  = 32;
   localparam int WeightWidth  = 17;

   // The weight is a fraction with a fixed 16-bit scale, independent of the average format.
   localparam int WeightFrac   = 16;
   localparam logic [WeightWidth-1:0] WeightOne = WeightWidth'(65536);

   // Configuration port.
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] CSR_RUN_COUNT        = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CSR_GAP_TICKS        = CsrIndexWidth'(1);
   localparam logic [CsrIndexWidth-1:0] CSR_SETTLE_TICKS     = CsrIndexWidth'(2);
   localparam logic [CsrIndexWidth-1:0] CSR_SMOOTHING_WEIGHT = CsrIndexWidth'(3);

   localparam logic [RunWidth-1:0]    RunCountReset  = RunWidth'(1);
   localparam logic [PeriodWidth-1:0] GapReset       = PeriodWidth'(500000);
   localparam logic [PeriodWidth-1:0] SettleReset    = PeriodWidth'(1000000);
   localparam logic [WeightWidth-1:0] WeightReset    = WeightWidth'(6554);

   localparam logic [CountWidth-1:0] CountMax = '1;
   localparam logic [AvgWidth-1:0]   AvgMax   = '1;

   // Latency scaled into the average format, before saturation.
   localparam int LqWideWidth = CountWidth + AvgFracBits;
   localparam int CmpWidth    = (LqWideWidth > AvgWidth) ? LqWideWidth : AvgWidth;

   // Difference of scaled latency and average, and its split for the multipliers.
   localparam int DiffWidth   = AvgWidth + 1;
   localparam int LoWidth     = 24;
   localparam int HiWidth     = DiffWidth - LoWidth;
   localparam int ProdLoWidth = WeightWidth + LoWidth;
   localparam int ProdHiWidth = WeightWidth + 1 + HiWidth;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETTLE,
      PH_WAIT,
      PH_MEASURE,
      PH_GAP
   } phase_type;

   typedef struct packed {
      logic [RunWidth-1:0]    run_count;
      logic [PeriodWidth-1:0] gap_ticks;
      logic [PeriodWidth-1:0] settle_ticks;
      logic [WeightWidth-1:0] smoothing_weight;
   } csr_type;

   typedef struct packed {
      logic                  emit;
      logic                  busy;
      logic                  sample;
      logic                  done;
      logic                  clear;
      logic [CountWidth-1:0] last_lat;
      logic [CountWidth-1:0] min_lat;
      logic [CountWidth-1:0] max_lat;
   } item_type;

endpackage
`default_nettype wire

### rtl/core/llm_csr.sv
`default_nettype none
module llm_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire logic [llm_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [llm_pkg::CsrDataWidth-1:0]   csr_write_data,
   output llm_pkg::csr_type                        csr
);
   import llm_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RUN_COUNT: begin
               csr_in.run_count = csr_write_data[RunWidth-1:0];
            end
            CSR_GAP_TICKS: begin
               csr_in.gap_ticks = csr_write_data[PeriodWidth-1:0];
            end
            CSR_SETTLE_TICKS: begin
               csr_in.settle_ticks = csr_write_data[PeriodWidth-1:0];
            end
            CSR_SMOOTHING_WEIGHT: begin
               csr_in.smoothing_weight = csr_write_data[WeightWidth-1:0];
            end
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.run_count        <= RunCountReset;
         csr_ff.gap_ticks        <= GapReset;
         csr_ff.settle_ticks     <= SettleReset;
         csr_ff.smoothing_weight <= WeightReset;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule
`default_nettype wire

### rtl/core/llm_ctrl.sv
`default_nettype none
module llm_ctrl (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic       accept,
   input  wire logic       recv_level,
   input  wire logic       start_request,
   input  wire llm_pkg::csr_type csr,
   output llm_pkg::item_type item,
   output logic            item_valid
);
   import llm_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [RunWidth-1:0]     runs_left_ff, runs_left_in;
   logic [PeriodWidth-1:0]  timer_ff, timer_in;
   logic [CountWidth-1:0]   counter_ff, counter_in;
   logic [CountWidth-1:0]   min_ff, min_in;
   logic [CountWidth-1:0]   max_ff, max_in;
   logic [CountWidth-1:0]   last_ff, last_in;
   logic                    sample_ff, sample_in;
   logic                    done_ff, done_in;
   logic                    clear_ff, clear_in;
   logic                    valid_ff, valid_in;

   logic [PeriodWidth-1:0]  period;
   logic                    timer_below;
   logic [CountWidth-1:0]   lat;
   logic [RunWidth-1:0]     runs_dec;

   assign period      = (phase_ff == PH_SETTLE) ? csr.settle_ticks : csr.gap_ticks;
   assign timer_below = timer_ff < period;
   assign lat         = (counter_ff < CountMax) ? counter_ff + CountWidth'(1) : CountMax;
   assign runs_dec    = (runs_left_ff == '0) ? '0 : runs_left_ff - RunWidth'(1);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start_request) phase_in = PH_SETTLE;
         end
         PH_SETTLE, PH_GAP: begin
            if (!timer_below) phase_in = (runs_left_ff == '0) ? PH_IDLE : PH_WAIT;
         end
         PH_WAIT: begin
            if (recv_level) phase_in = PH_MEASURE;
         end
         PH_MEASURE: begin
            if (!recv_level) phase_in = PH_GAP;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Counters, statistics and per-request flags.
   always_comb begin
      runs_left_in = runs_left_ff;
      timer_in     = timer_ff;
      counter_in   = counter_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      last_in      = last_ff;
      sample_in    = 1'b0;
      done_in      = 1'b0;
      clear_in     = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start_request) begin
               runs_left_in = csr.run_count;
               timer_in     = '0;
               counter_in   = '0;
               min_in       = CountMax;
               max_in       = '0;
               last_in      = '0;
               clear_in     = 1'b1;
            end
         end
         PH_SETTLE, PH_GAP: begin
            if (timer_below) begin
               timer_in = timer_ff + PeriodWidth'(1);
            end else if (runs_left_ff == '0 && phase_ff == PH_SETTLE) begin
               done_in = 1'b1;
            end
         end
         PH_WAIT: begin
            if (recv_level) counter_in = '0;
         end
         PH_MEASURE: begin
            if (recv_level) begin
               if (counter_ff < CountMax) counter_in = counter_ff + CountWidth'(1);
            end else begin
               last_in      = lat;
               if (lat < min_ff) min_in = lat;
               if (lat > max_ff) max_in = lat;
               sample_in    = 1'b1;
               runs_left_in = runs_dec;
               done_in      = (runs_dec == '0);
               timer_in     = '0;
            end
         end
         default: begin
            sample_in = 1'b0;
         end
      endcase
   end

   assign valid_in = advance ? accept : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         runs_left_ff <= '0;
         timer_ff     <= '0;
         counter_ff   <= '0;
         min_ff       <= CountMax;
         max_ff       <= '0;
         last_ff      <= '0;
         sample_ff    <= 1'b0;
         done_ff      <= 1'b0;
         clear_ff     <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            phase_ff     <= phase_in;
            runs_left_ff <= runs_left_in;
            timer_ff     <= timer_in;
            counter_ff   <= counter_in;
            min_ff       <= min_in;
            max_ff       <= max_in;
            last_ff      <= last_in;
            sample_ff    <= sample_in;
            done_ff      <= done_in;
            clear_ff     <= clear_in;
         end
      end
   end

   // The state registers themselves hold the values after the latest request.
   always_comb begin
      item.emit     = (phase_ff == PH_MEASURE);
      item.busy     = (phase_ff != PH_IDLE);
      item.sample   = sample_ff;
      item.done     = done_ff;
      item.clear    = clear_ff;
      item.last_lat = last_ff;
      item.min_lat  = min_ff;
      item.max_lat  = max_ff;
   end

   assign item_valid = valid_ff;

endmodule
`default_nettype wire

### rtl/core/llm_avg.sv
`default_nettype none
module llm_avg (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire llm_pkg::item_type               item,
   input  wire logic                            item_valid,
   input  wire logic [llm_pkg::WeightWidth-1:0] smoothing_weight,
   output llm_pkg::item_type                    out_item,
   output logic [llm_pkg::CountWidth-1:0]       out_jitter,
   output logic [llm_pkg::AvgWidth-1:0]         out_average,
   output logic                                 out_valid
);
   import llm_pkg::*;

   typedef struct packed {
      item_type                     item;
      logic [CountWidth-1:0]        jitter;
      logic signed [DiffWidth-1:0]  diff;
   } diff_stage_type;

   typedef struct packed {
      item_type                       item;
      logic [CountWidth-1:0]          jitter;
      logic signed [ProdHiWidth-1:0]  prod_hi;
      logic [ProdLoWidth-1:0]         prod_lo;
   } prod_stage_type;

   typedef struct packed {
      item_type               item;
      logic [CountWidth-1:0]  jitter;
   } out_stage_type;

   diff_stage_type s2_ff, s2_in;
   prod_stage_type s3_ff, s3_in;
   out_stage_type  s4_ff, s4_in;
   logic           v2_ff, v3_ff, v4_ff;
   logic [AvgWidth-1:0] avg_ff, avg_in;

   logic [CmpWidth-1:0]          lq_wide;
   logic [AvgWidth-1:0]          lq;
   logic [WeightWidth-1:0]       weight;
   logic signed [WeightWidth:0]  weight_s;
   logic signed [HiWidth-1:0]    diff_hi;
   logic [LoWidth-1:0]           diff_lo;
   logic [AvgWidth-1:0]          hi_term;
   logic [AvgWidth-1:0]          lo_term;

   // Stage 2: scaled latency minus the running average. A new sample is always
   // at least three requests behind the previous one, so the average here is
   // already up to date.
   always_comb begin
      lq_wide = CmpWidth'(item.last_lat) << AvgFracBits;
      lq      = (lq_wide > CmpWidth'(AvgMax)) ? AvgMax : lq_wide[AvgWidth-1:0];
      s2_in.item   = item;
      s2_in.jitter = (item.max_lat >= item.min_lat) ? item.max_lat - item.min_lat : '0;
      s2_in.diff   = $signed({1'b0, lq}) - $signed({1'b0, avg_ff});
   end

   // Stage 3: weight times difference, split into two narrow products.
   always_comb begin
      weight   = (smoothing_weight > WeightOne) ? WeightOne : smoothing_weight;
      weight_s = $signed({1'b0, weight});
      diff_hi  = s2_ff.diff[DiffWidth-1:LoWidth];
      diff_lo  = s2_ff.diff[LoWidth-1:0];
      s3_in.item    = s2_ff.item;
      s3_in.jitter  = s2_ff.jitter;
      s3_in.prod_hi = weight_s * diff_hi;
      s3_in.prod_lo = weight * diff_lo;
   end

   // Stage 4: avg + (w * diff) >>> 16, taken modulo the average width. The
   // true result always lies in range, so the wrap is exact.
   always_comb begin
      hi_term = AvgWidth'(s3_ff.prod_hi) << (LoWidth - WeightFrac);
      lo_term = AvgWidth'(s3_ff.prod_lo[ProdLoWidth-1:WeightFrac]);
      s4_in.item   = s3_ff.item;
      s4_in.jitter = s3_ff.jitter;
      avg_in = avg_ff;
      if (v3_ff && s3_ff.item.clear) begin
         avg_in = '0;
      end else if (v3_ff && s3_ff.item.sample) begin
         avg_in = avg_ff + hi_term + lo_term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         avg_ff <= '0;
      end else if (advance) begin
         v2_ff  <= item_valid;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         avg_ff <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_item    = s4_ff.item;
   assign out_jitter  = s4_ff.jitter;
   assign out_average = avg_ff;
   assign out_valid   = v4_ff;

endmodule
`default_nettype wire

### rtl/core/loopback_latency_meter.sv
`default_nettype none
// Loopback latency meter. Each request is one timer tick carrying the sampled
// receiver pin and a start bit, and it yields exactly one response holding the
// emitter and LED levels, the latest latency, minimum, maximum, jitter and a
// Q16 moving average as they stand after that tick. One request is accepted
// every clock cycle unless req_stall is high; its response passes the control
// registers and the average datapath (difference, split multiply, accumulate).
// rsp_stall freezes it while rsp_valid is high; req_stall rises the same cycle.
module loopback_latency_meter (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_recv_level,
   input  wire logic                               req_start_request,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_emit_level,
   output logic                                    rsp_led_level,
   output logic                                    rsp_sample_valid,
   output logic [llm_pkg::TicksWidth-1:0]          rsp_latency_ticks,
   output logic [llm_pkg::TicksWidth-1:0]          rsp_min_ticks,
   output logic [llm_pkg::TicksWidth-1:0]          rsp_max_ticks,
   output logic [llm_pkg::TicksWidth-1:0]          rsp_jitter_ticks,
   output logic [llm_pkg::AvgWidth-1:0]            rsp_average_q16,
   output logic                                    rsp_test_done,
   output logic                                    rsp_busy_res,

   input  wire logic                               csr_write_en,
   input  wire logic [llm_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [llm_pkg::CsrDataWidth-1:0]   csr_write_data
);
   import llm_pkg::*;

   csr_type               csr;
   item_type              item;
   logic                  item_valid;
   item_type              out_item;
   logic [CountWidth-1:0] out_jitter;
   logic [AvgWidth-1:0]   out_average;
   logic                  out_valid;
   logic                  advance;
   logic                  accept;

   assign advance   = !out_valid || !rsp_stall;
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   llm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .csr            (csr)
   );

   llm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .accept        (accept),
      .recv_level    (req_recv_level),
      .start_request (req_start_request),
      .csr           (csr),
      .item          (item),
      .item_valid    (item_valid)
   );

   llm_avg u_avg (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .item             (item),
      .item_valid       (item_valid),
      .smoothing_weight (csr.smoothing_weight),
      .out_item         (out_item),
      .out_jitter       (out_jitter),
      .out_average      (out_average),
      .out_valid        (out_valid)
   );

   assign rsp_valid         = out_valid;
   assign rsp_emit_level    = out_item.emit;
   assign rsp_led_level     = out_item.busy;
   assign rsp_sample_valid  = out_item.sample;
   assign rsp_latency_ticks = TicksWidth'(out_item.last_lat);
   assign rsp_min_ticks     = TicksWidth'(out_item.min_lat);
   assign rsp_max_ticks     = TicksWidth'(out_item.max_lat);
   assign rsp_jitter_ticks  = TicksWidth'(out_jitter);
   assign rsp_average_q16   = out_average;
   assign rsp_test_done     = out_item.done;
   assign rsp_busy_res      = out_item.busy;

endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
   import llm_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int RandomTicks = 1600;
   localparam int CalmFrom    = 1500;
   localparam int CalmTo      = 3000;
   localparam logic [CountWidth-1:0] AllOnes = '1;

   typedef struct {
      logic                   emit;
      logic                   led;
      logic                   sample;
      logic [TicksWidth-1:0]  latency;
      logic [TicksWidth-1:0]  min_lat;
      logic [TicksWidth-1:0]  max_lat;
      logic [TicksWidth-1:0]  jitter;
      logic [AvgWidth-1:0]    average;
      logic                   done;
      logic                   busy;
   } reading_type;

   typedef enum {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic                     recv;
      logic                     start;
      bit                       typed;
      reading_type              want;
      logic [CsrIndexWidth-1:0] index;
      logic [CsrDataWidth-1:0]  data;
   } tick_row_type;

   typedef struct {
      bit          typed;
      reading_type want;
   } tick_note_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_recv_level = 1'b0;
   logic                      req_start_request = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_emit_level;
   logic                      rsp_led_level;
   logic                      rsp_sample_valid;
   logic [TicksWidth-1:0]     rsp_latency_ticks;
   logic [TicksWidth-1:0]     rsp_min_ticks;
   logic [TicksWidth-1:0]     rsp_max_ticks;
   logic [TicksWidth-1:0]     rsp_jitter_ticks;
   logic [AvgWidth-1:0]       rsp_average_q16;
   logic                      rsp_test_done;
   logic                      rsp_busy_res;
   logic                      csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0]   csr_write_data = '0;

   int  cycles = 0;
   int  errors = 0;
   int  requests_seen = 0;
   int  samples_seen = 0;
   int  tests_done = 0;
   bit  calm;

   // Predicted meter state and its configuration copy.
   phase_type               meter_phase = PH_IDLE;
   logic [RunWidth-1:0]     runs_remaining = '0;
   logic [PeriodWidth-1:0]  tick_timer = '0;
   logic [CountWidth-1:0]   hold_count = '0;
   logic [CountWidth-1:0]   lat_min = '1;
   logic [CountWidth-1:0]   lat_max = '0;
   logic [CountWidth-1:0]   lat_last = '0;
   logic [AvgWidth-1:0]     lat_avg = '0;
   logic [RunWidth-1:0]     cfg_runs = RunCountReset;
   logic [PeriodWidth-1:0]  cfg_gap = GapReset;
   logic [PeriodWidth-1:0]  cfg_settle = SettleReset;
   logic [WeightWidth-1:0]  cfg_weight = WeightReset;

   reading_type   pending_readings[$];
   tick_note_type accept_notes[$];
   tick_row_type  directed_rows[$];
   reading_type   no_reading;

   loopback_latency_meter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_recv_level    (req_recv_level),
      .req_start_request (req_start_request),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_emit_level    (rsp_emit_level),
      .rsp_led_level     (rsp_led_level),
      .rsp_sample_valid  (rsp_sample_valid),
      .rsp_latency_ticks (rsp_latency_ticks),
      .rsp_min_ticks     (rsp_min_ticks),
      .rsp_max_ticks     (rsp_max_ticks),
      .rsp_jitter_ticks  (rsp_jitter_ticks),
      .rsp_average_q16   (rsp_average_q16),
      .rsp_test_done     (rsp_test_done),
      .rsp_busy_res      (rsp_busy_res),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   assign calm = (cycles >= CalmFrom) && (cycles < CalmTo);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 32);
   end

   // Advances the predicted meter by one tick and returns the outputs after it.
   function automatic reading_type step_meter(logic recv, logic start);
      reading_type             r;
      logic [CountWidth-1:0]   lat;
      logic [PeriodWidth-1:0]  period;
      logic [65:0]             w;
      logic [65:0]             acc;
      r.sample = 1'b0;
      r.done = 1'b0;
      case (meter_phase)
         PH_IDLE: begin
            if (start) begin
               runs_remaining = cfg_runs;
               tick_timer = '0;
               hold_count = '0;
               lat_min = AllOnes;
               lat_max = '0;
               lat_avg = '0;
               lat_last = '0;
               meter_phase = PH_SETTLE;
            end
         end
         PH_SETTLE, PH_GAP: begin
            period = (meter_phase == PH_SETTLE) ? cfg_settle : cfg_gap;
            if (tick_timer < period) begin
               tick_timer = tick_timer + 1'b1;
            end else if (runs_remaining == 0) begin
               // Only a test with zero runs reports completion out of settle.
               r.done = (meter_phase == PH_SETTLE);
               meter_phase = PH_IDLE;
            end else begin
               meter_phase = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (recv) begin
               hold_count = '0;
               meter_phase = PH_MEASURE;
            end
         end
         PH_MEASURE: begin
            if (recv) begin
               if (hold_count != AllOnes) hold_count = hold_count + 1'b1;
            end else begin
               lat = (hold_count != AllOnes) ? hold_count + 1'b1 : hold_count;
               lat_last = lat;
               if (lat < lat_min) lat_min = lat;
               if (lat > lat_max) lat_max = lat;
               w = (cfg_weight > WeightOne) ? 66'(WeightOne) : 66'(cfg_weight);
               acc = w * (66'(lat) << AvgFracBits) + (66'(WeightOne) - w) * 66'(lat_avg);
               lat_avg = acc[AvgWidth+WeightFrac-1:WeightFrac];
               r.sample = 1'b1;
               if (runs_remaining != 0) runs_remaining = runs_remaining - 1'b1;
               if (runs_remaining == 0) r.done = 1'b1;
               tick_timer = '0;
               meter_phase = PH_GAP;
            end
         end
         default: meter_phase = PH_IDLE;
      endcase
      r.emit = (meter_phase == PH_MEASURE);
      r.busy = (meter_phase != PH_IDLE);
      r.led = r.busy;
      r.latency = lat_last;
      r.min_lat = lat_min;
      r.max_lat = lat_max;
      r.jitter = (lat_max >= lat_min) ? lat_max - lat_min : '0;
      r.average = lat_avg;
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      tick_note_type note;
      reading_type   r;
      reading_type   want;
      if (!reset && req_valid && !req_stall) begin
         note = accept_notes.pop_front();
         r = step_meter(req_recv_level, req_start_request);
         pending_readings.push_back(note.typed ? note.want : r);
         requests_seen++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $error("response arrived with no request outstanding");
            errors++;
         end else begin
            want = pending_readings.pop_front();
            check_field("emit_level", want.emit, rsp_emit_level);
            check_field("led_level", want.led, rsp_led_level);
            check_field("sample_valid", want.sample, rsp_sample_valid);
            check_field("latency_ticks", want.latency, rsp_latency_ticks);
            check_field("min_ticks", want.min_lat, rsp_min_ticks);
            check_field("max_ticks", want.max_lat, rsp_max_ticks);
            check_field("jitter_ticks", want.jitter, rsp_jitter_ticks);
            check_field("average_q16", want.average, rsp_average_q16);
            check_field("test_done", want.done, rsp_test_done);
            check_field("busy_res", want.busy, rsp_busy_res);
            if (rsp_sample_valid === 1'b1) samples_seen++;
            if (rsp_test_done === 1'b1) tests_done++;
         end
      end
   end

   task automatic send_tick(logic recv, logic start, bit typed, reading_type want);
      tick_note_type note;
      note.typed = typed;
      note.want = want;
      csr_write_en <= 1'b0;
      while (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      accept_notes.push_back(note);
      req_valid <= 1'b1;
      req_recv_level <= recv;
      req_start_request <= start;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds off new requests until every outstanding response is back.
   task automatic drain();
      req_valid <= 1'b0;
      csr_write_en <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] index, logic [CsrDataWidth-1:0] data);
      case (index)
         CSR_RUN_COUNT:        cfg_runs = data[RunWidth-1:0];
         CSR_GAP_TICKS:        cfg_gap = data[PeriodWidth-1:0];
         CSR_SETTLE_TICKS:     cfg_settle = data[PeriodWidth-1:0];
         CSR_SMOOTHING_WEIGHT: cfg_weight = data[WeightWidth-1:0];
         default: ;
      endcase
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   function automatic void add_tick(logic recv, logic start);
      tick_row_type row;
      row.kind = ROW_TICK;
      row.recv = recv;
      row.start = start;
      row.typed = 1'b0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(logic recv, logic start, reading_type want);
      tick_row_type row;
      row.kind = ROW_TICK;
      row.recv = recv;
      row.start = start;
      row.typed = 1'b1;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(logic [CsrIndexWidth-1:0] index,
                                     logic [CsrDataWidth-1:0] data);
      tick_row_type row;
      row.kind = ROW_WRITE;
      row.index = index;
      row.data = data;
      directed_rows.push_back(row);
   endfunction

   initial begin
      int   random_sent;
      int   phase_no;
      int   phase_len;
      int   run_left;
      bit   noisy;
      logic recv_now;
      logic start_now;
      logic [CsrDataWidth-1:0] runs;
      logic [CsrDataWidth-1:0] gap;
      logic [CsrDataWidth-1:0] settle;
      logic [CsrDataWidth-1:0] weight;

      // Two runs with a full weight, so the average is just the latest latency.
      add_write(CSR_RUN_COUNT, 2);
      add_write(CSR_GAP_TICKS, 1);
      add_write(CSR_SETTLE_TICKS, 2);
      add_write(CSR_SMOOTHING_WEIGHT, 65536);
      add_checked(0, 0, reading_type'{0, 0, 0, 0, AllOnes, 0, 0, 0, 0, 0});
      add_checked(0, 1, reading_type'{0, 1, 0, 0, AllOnes, 0, 0, 0, 0, 1});
      add_checked(1, 0, reading_type'{0, 1, 0, 0, AllOnes, 0, 0, 0, 0, 1});
      add_checked(0, 0, reading_type'{0, 1, 0, 0, AllOnes, 0, 0, 0, 0, 1});
      add_checked(0, 0, reading_type'{0, 1, 0, 0, AllOnes, 0, 0, 0, 0, 1});
      add_checked(0, 0, reading_type'{0, 1, 0, 0, AllOnes, 0, 0, 0, 0, 1});
      add_checked(1, 0, reading_type'{1, 1, 0, 0, AllOnes, 0, 0, 0, 0, 1});
      add_checked(1, 0, reading_type'{1, 1, 0, 0, AllOnes, 0, 0, 0, 0, 1});
      add_checked(0, 0, reading_type'{0, 1, 1, 2, 2, 2, 0, 131072, 0, 1});
      // A start while busy must be ignored.
      add_checked(1, 1, reading_type'{0, 1, 0, 2, 2, 2, 0, 131072, 0, 1});
      add_checked(0, 0, reading_type'{0, 1, 0, 2, 2, 2, 0, 131072, 0, 1});
      add_checked(1, 0, reading_type'{1, 1, 0, 2, 2, 2, 0, 131072, 0, 1});
      add_checked(0, 0, reading_type'{0, 1, 1, 1, 1, 2, 1, 65536, 1, 1});
      add_checked(0, 0, reading_type'{0, 1, 0, 1, 1, 2, 1, 65536, 0, 1});
      add_checked(0, 0, reading_type'{0, 0, 0, 1, 1, 2, 1, 65536, 0, 0});
      // Zero runs: the test ends straight out of settle.
      add_write(CSR_RUN_COUNT, 0);
      add_write(CSR_SETTLE_TICKS, 0);
      add_checked(0, 1, reading_type'{0, 1, 0, 0, AllOnes, 0, 0, 0, 0, 1});
      add_checked(0, 0, reading_type'{0, 0, 0, 0, AllOnes, 0, 0, 0, 1, 0});
      // A weight above one is clamped to one.
      add_write(CSR_RUN_COUNT, 1);
      add_write(CSR_GAP_TICKS, 0);
      add_write(CSR_SMOOTHING_WEIGHT, 32'h1_FFFF);
      add_tick(0, 1);
      add_tick(0, 0);
      add_tick(1, 0);
      add_tick(1, 1);
      add_tick(0, 0);
      add_tick(0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain();
            write_reg(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_tick(directed_rows[i].recv, directed_rows[i].start,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      random_sent = 0;
      phase_no = 0;
      recv_now = 1'b0;
      run_left = 0;
      while (random_sent < RandomTicks) begin
         runs = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
         gap = $urandom_range(0, 6);
         settle = $urandom_range(0, 6);
         case ($urandom_range(0, 4))
            0:       weight = 0;
            1:       weight = 65536;
            2:       weight = 32'h1_FFFF;
            3:       weight = $urandom_range(65537, 131071);
            default: weight = $urandom_range(0, 65536);
         endcase
         // The first phases force the longest periods and the zero weight; the
         // following phase shortens the period again so the test can move on.
         case (phase_no)
            0:       settle = '1;
            1:       gap = '1;
            2:       weight = 0;
            default: ;
         endcase
         drain();
         write_reg(CSR_RUN_COUNT, runs);
         write_reg(CSR_GAP_TICKS, gap);
         write_reg(CSR_SETTLE_TICKS, settle);
         write_reg(CSR_SMOOTHING_WEIGHT, weight);
         noisy = ($urandom_range(4) == 0);
         phase_len = $urandom_range(60, 140);
         for (int k = 0; k < phase_len; k++) begin
            if (noisy) begin
               recv_now = $urandom_range(0, 1);
               start_now = $urandom_range(0, 1);
            end else begin
               // Receiver level moves in pulses so runs are measured end to end.
               if (run_left == 0) begin
                  recv_now = !recv_now;
                  run_left = ($urandom_range(7) == 0) ? $urandom_range(7, 20)
                                                      : $urandom_range(1, 6);
               end
               run_left--;
               start_now = ($urandom_range(9) == 0);
            end
            send_tick(recv_now, start_now, 1'b0, no_reading);
         end
         random_sent += phase_len;
         phase_no++;
      end

      // The largest run count goes last: that test need not finish.
      drain();
      write_reg(CSR_RUN_COUNT, 65535);
      write_reg(CSR_GAP_TICKS, 0);
      write_reg(CSR_SETTLE_TICKS, 0);
      write_reg(CSR_SMOOTHING_WEIGHT, $urandom_range(0, 65536));
      for (int k = 0; k < 80; k++) begin
         send_tick(k[1] ^ k[0], (k == 0), 1'b0, no_reading);
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Ran %0d requests over %0d random phases:", requests_seen, phase_no);
      $display("%0d latencies published, %0d tests done.", samples_seen, tests_done);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/llm_pkg.sv
rtl/core/llm_csr.sv
rtl/core/llm_ctrl.sv
rtl/core/llm_avg.sv
rtl/core/loopback_latency_meter.sv
tb/tb_top.sv
